// File: rtl/core/mks_pkg.sv
package mks_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W   = 24;
    localparam int POT_W   = 10;
    localparam int MIDI_W  = 7;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam int NUM_KEYS_DEF = 24;

    // Action codes
    localparam logic [1:0] ACT_SCAN    = 2'd0;
    localparam logic [1:0] ACT_ENCODER = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_VOL_THRESH = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HOLDOFF    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_BASE_NOTE  = 2'd2;
    localparam logic [CIDX_W-1:0] REG_VELOCITY   = 2'd3;

    // Register reset values
    localparam logic [MIDI_W-1:0] THRESH_RST   = 7'd2;
    localparam logic [CFG_W-1:0]  HOLDOFF_RST  = 16'd200;
    localparam logic [MIDI_W-1:0] BASE_RST     = 7'd48;
    localparam logic [MIDI_W-1:0] VELOCITY_RST = 7'd127;

    // MIDI codes
    localparam logic [7:0]        ST_NOTE_ON  = 8'h90;
    localparam logic [7:0]        ST_NOTE_OFF = 8'h80;
    localparam logic [7:0]        ST_CONTROL  = 8'hB0;
    localparam logic [7:0]        ST_PROGRAM  = 8'hC0;
    localparam logic [MIDI_W-1:0] CC_VOLUME   = 7'h07;
    localparam logic [MIDI_W-1:0] MIDI_MAX    = 7'd127;

    localparam logic signed [3:0] OCT_MAX = 4'sd4;
    localparam logic signed [3:0] OCT_MIN = -4'sd4;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key_levels;
        logic [POT_W-1:0] pot_sample;
        logic             button_level;
        logic             clock_level;
        logic             direction_level;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        status_byte;
        logic [MIDI_W-1:0] first_data;
        logic [MIDI_W-1:0] second_data;
        logic              last_message;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VOL,
        ST_PROG,
        ST_KEYS
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic do_vol;
        logic do_prog;
        logic do_key;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_scan;
        logic can_emit;
        logic key_last;
    } stat_t;

endpackage

// File: rtl/core/mks_ctrl.sv
module mks_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mks_pkg::stat_t  stat,
    output mks_pkg::cmd_t   cmd
);
    import mks_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.in_scan)
                begin
                    state_next = ST_VOL;
                end
            end
            ST_VOL:
            begin
                if (stat.can_emit)
                begin
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                if (stat.can_emit)
                begin
                    state_next = ST_KEYS;
                end
            end
            ST_KEYS:
            begin
                if (stat.can_emit && stat.key_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: each scan step after the accept waits for room in the output register
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cmd.accept  = (state_reg == ST_IDLE) && in_valid;
        cmd.do_vol  = (state_reg == ST_VOL)  && stat.can_emit;
        cmd.do_prog = (state_reg == ST_PROG) && stat.can_emit;
        cmd.do_key  = (state_reg == ST_KEYS) && stat.can_emit;
    end

endmodule

// File: rtl/core/mks_dp.sv
module mks_dp
#(
    parameter int NUM_KEYS = mks_pkg::NUM_KEYS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mks_pkg::in_word_t            in_data,
    input  mks_pkg::cmd_t                cmd,
    output mks_pkg::stat_t               stat,
    input  logic                         cfg_we,
    input  logic [mks_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mks_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output mks_pkg::out_word_t           out_data
);
    import mks_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_KEYS - 1);

    // Configuration
    logic [MIDI_W-1:0] thresh_reg;
    logic [CFG_W-1:0]  holdoff_reg;
    logic [MIDI_W-1:0] base_reg;
    logic [MIDI_W-1:0] vel_reg;

    // Control state
    logic [NUM_KEYS-1:0] key_state_reg, key_state_next;
    logic [NUM_KEYS-1:0] pend_reg, pend_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic signed [7:0]   last_vol_reg, last_vol_next;
    logic                mode_reg, mode_next;
    logic [MIDI_W-1:0]   cur_prog_reg, cur_prog_next;
    logic [MIDI_W-1:0]   sent_prog_reg, sent_prog_next;
    logic signed [3:0]   oct_reg, oct_next;
    logic                last_clk_reg, last_clk_next;
    logic [31:0]         ms_reg, ms_next;
    logic [31:0]         press_reg, press_next;
    logic                out_valid_reg, out_valid_next;

    // Payload
    logic [NUM_KEYS-1:0] lvl_reg;
    logic [POT_W-1:0]    pot_reg;
    logic                btn_reg;
    out_word_t           out_data_reg;

    // Volume, button and note arithmetic
    logic [16:0]         pot_x127;
    logic [6:0]          vol_q0;
    logic [10:0]         vol_rem;
    logic [MIDI_W-1:0]   vol;
    logic signed [8:0]   vol_diff;
    logic [8:0]          vol_mag;
    logic                vol_send;
    logic                btn_toggle;
    logic                mode_after;
    logic                prog_diff;
    logic signed [9:0]   oct_ext;
    logic signed [9:0]   note_sum;
    logic [MIDI_W-1:0]   note;
    logic [NUM_KEYS-1:0] pend_after;
    logic                emit;
    out_word_t           emit_word;
    logic                step_up;

    // pot*127/1023: x/1023 = (x>>10) plus at most one correction
    always_comb
    begin
        pot_x127 = {pot_reg, 7'b0} - {7'b0, pot_reg};
        vol_q0   = pot_x127[16:10];
        vol_rem  = {1'b0, pot_x127[9:0]} + {4'b0, vol_q0};
        vol      = (vol_rem >= 11'd1023) ? (vol_q0 + 7'd1) : vol_q0;
        vol_diff = $signed({2'b00, vol}) - $signed({last_vol_reg[7], last_vol_reg});
        vol_mag  = vol_diff[8] ? 9'(-vol_diff) : 9'(vol_diff);
        vol_send = (vol_mag > {2'b00, thresh_reg});
    end

    // Button hold-off and program check
    always_comb
    begin
        btn_toggle = !btn_reg && ((ms_reg - press_reg) > {16'b0, holdoff_reg});
        mode_after = mode_reg ^ btn_toggle;
        prog_diff  = (cur_prog_reg != sent_prog_reg);
    end

    // Note number for the current key, clamped to the MIDI range
    always_comb
    begin
        oct_ext  = {{6{oct_reg[3]}}, oct_reg};
        note_sum = $signed({3'b000, base_reg}) + $signed(10'(idx_reg))
                 + (oct_ext <<< 3) + (oct_ext <<< 2);
        if (note_sum < 10'sd0)
        begin
            note = '0;
        end
        else if (note_sum > 10'sd127)
        begin
            note = MIDI_MAX;
        end
        else
        begin
            note = note_sum[MIDI_W-1:0];
        end
        pend_after = pend_reg & ~(NUM_KEYS'(1) << idx_reg);
    end

    // Message build
    always_comb
    begin
        emit      = 1'b0;
        emit_word = '0;
        if (cmd.do_vol && vol_send)
        begin
            emit                   = 1'b1;
            emit_word.status_byte  = ST_CONTROL;
            emit_word.first_data   = CC_VOLUME;
            emit_word.second_data  = vol;
            emit_word.last_message = !(mode_after && prog_diff) && (pend_reg == '0);
        end
        else if (cmd.do_prog && mode_reg && prog_diff)
        begin
            emit                   = 1'b1;
            emit_word.status_byte  = ST_PROGRAM;
            emit_word.first_data   = cur_prog_reg;
            emit_word.second_data  = '0;
            emit_word.last_message = (pend_reg == '0);
        end
        else if (cmd.do_key && pend_reg[idx_reg])
        begin
            emit                   = 1'b1;
            emit_word.status_byte  = lvl_reg[idx_reg] ? ST_NOTE_OFF : ST_NOTE_ON;
            emit_word.first_data   = note;
            emit_word.second_data  = vel_reg;
            emit_word.last_message = (pend_after == '0);
        end
    end

    // State update
    always_comb
    begin
        key_state_next = key_state_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        last_vol_next  = last_vol_reg;
        mode_next      = mode_reg;
        cur_prog_next  = cur_prog_reg;
        sent_prog_next = sent_prog_reg;
        oct_next       = oct_reg;
        last_clk_next  = last_clk_reg;
        ms_next        = ms_reg;
        press_next     = press_reg;
        step_up        = (in_data.direction_level != in_data.clock_level);

        if (cmd.accept)
        begin
            unique case (in_data.action)
                ACT_SCAN:
                begin
                    pend_next      = in_data.key_levels[NUM_KEYS-1:0] ^ key_state_reg;
                    key_state_next = in_data.key_levels[NUM_KEYS-1:0];
                    idx_next       = '0;
                end
                ACT_ENCODER:
                begin
                    if (in_data.clock_level != last_clk_reg)
                    begin
                        if (mode_reg)
                        begin
                            if (step_up && cur_prog_reg != MIDI_MAX)
                            begin
                                cur_prog_next = cur_prog_reg + 7'd1;
                            end
                            else if (!step_up && cur_prog_reg != '0)
                            begin
                                cur_prog_next = cur_prog_reg - 7'd1;
                            end
                        end
                        else
                        begin
                            if (step_up && oct_reg != OCT_MAX)
                            begin
                                oct_next = oct_reg + 4'sd1;
                            end
                            else if (!step_up && oct_reg != OCT_MIN)
                            begin
                                oct_next = oct_reg - 4'sd1;
                            end
                        end
                    end
                    last_clk_next = in_data.clock_level;
                end
                ACT_TICK:
                begin
                    ms_next = ms_reg + 32'd1;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.do_vol)
        begin
            if (vol_send)
            begin
                last_vol_next = $signed({1'b0, vol});
            end
            if (btn_toggle)
            begin
                mode_next  = !mode_reg;
                press_next = ms_reg;
            end
        end

        if (cmd.do_prog && mode_reg && prog_diff)
        begin
            sent_prog_next = cur_prog_reg;
        end

        if (cmd.do_key)
        begin
            pend_next = pend_after;
            idx_next  = (idx_reg == IDX_LAST) ? '0 : (idx_reg + IDX_W'(1));
        end
    end

    // Output register
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RST;
            holdoff_reg   <= HOLDOFF_RST;
            base_reg      <= BASE_RST;
            vel_reg       <= VELOCITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VOL_THRESH: thresh_reg  <= cfg_data[MIDI_W-1:0];
                REG_HOLDOFF:    holdoff_reg <= cfg_data;
                REG_BASE_NOTE:  base_reg    <= cfg_data[MIDI_W-1:0];
                REG_VELOCITY:   vel_reg     <= cfg_data[MIDI_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_state_reg <= '1;
            pend_reg      <= '0;
            idx_reg       <= '0;
            last_vol_reg  <= -8'sd1;
            mode_reg      <= 1'b1;
            cur_prog_reg  <= '0;
            sent_prog_reg <= '0;
            oct_reg       <= '0;
            last_clk_reg  <= 1'b1;
            ms_reg        <= '0;
            press_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_state_reg <= key_state_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            last_vol_reg  <= last_vol_next;
            mode_reg      <= mode_next;
            cur_prog_reg  <= cur_prog_next;
            sent_prog_reg <= sent_prog_next;
            oct_reg       <= oct_next;
            last_clk_reg  <= last_clk_next;
            ms_reg        <= ms_next;
            press_reg     <= press_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_data.action == ACT_SCAN)
        begin
            lvl_reg <= in_data.key_levels[NUM_KEYS-1:0];
            pot_reg <= in_data.pot_sample;
            btn_reg <= in_data.button_level;
        end
        if (emit)
        begin
            out_data_reg <= emit_word;
        end
    end

    assign stat.in_scan  = (in_data.action == ACT_SCAN);
    assign stat.can_emit = !out_valid_reg || out_ready;
    assign stat.key_last = (idx_reg == IDX_LAST);
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    // Octave shift stays in its range
    a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (oct_reg <= OCT_MAX) && (oct_reg >= OCT_MIN))
        else $error("octave shift out of range");

    // A note word marked last leaves no key pending
    a_last_key: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_key && emit && emit_word.last_message) |=> (pend_reg == '0))
        else $error("keys still pending after last word");

    // After a program step in instrument mode the sent program is current
    a_prog_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_prog && mode_reg) |=> (sent_prog_reg == cur_prog_reg))
        else $error("program change not recorded");

    // The key sweep ends with every changed key handled
    a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_key && idx_reg == IDX_LAST) |=> (pend_reg == '0))
        else $error("key sweep left keys pending");

endmodule

// File: rtl/core/midi_key_scan_controller.sv
// Keyboard scan front end that turns scan, encoder and tick words into MIDI
// words. An encoder or tick word, and an unused action code, are handled as
// they are accepted. A scan word goes through steps: one to accept, one for
// the volume and button step, one for the program step, then a sweep over the
// keys at one key per cycle while the output side keeps up. Every scan step
// after the accept, whether or not it produces a word, waits while the output
// register is still full and out_ready is low. Input is taken only between
// scans; registers are written on cfg_we with no wait.
module midi_key_scan_controller
#(
    parameter int NUM_KEYS = mks_pkg::NUM_KEYS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mks_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mks_pkg::out_word_t           out_data,
    input  logic                         cfg_we,
    input  logic [mks_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mks_pkg::CFG_W-1:0]    cfg_data
);
    import mks_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mks_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mks_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
